/* src/lpsb_pkg.sv */
// ----------------------------------------------------------------------------
// lpsb_pkg: shared types and constants for the packet scan binner
// Framing bytes, CRC-8 step, status codes, sequencer states.
// ----------------------------------------------------------------------------
package lpsb_pkg;

  localparam int unsigned PACKET_BYTES      = 47;
  localparam int unsigned POINTS_PER_PACKET = 12;
  localparam int unsigned NBINS             = 360;
  localparam int unsigned MEM_DEPTH         = 2 * NBINS;

  localparam logic [7:0] HDR_BYTE = 8'h54;
  localparam logic [7:0] VER_BYTE = 8'h2C;
  localparam logic [7:0] CRC_POLY = 8'h4D;

  // byte positions inside a packet
  localparam logic [5:0] POS_START_LO = 6'd4;
  localparam logic [5:0] POS_START_HI = 6'd5;
  localparam logic [5:0] POS_PTS_LO   = 6'd6;
  localparam logic [5:0] POS_PTS_HI   = 6'd41;
  localparam logic [5:0] POS_END_LO   = 6'd42;
  localparam logic [5:0] POS_END_HI   = 6'd43;
  localparam logic [5:0] POS_CRC      = 6'(PACKET_BYTES - 1);

  // angle arithmetic, numerators in 1/1100 degree
  localparam logic [16:0] FULL_TURN_CDEG = 17'd36000;
  localparam logic [20:0] FULL_TURN_NUM  = 21'd396000;
  localparam logic [20:0] HALF_BIN_NUM   = 21'd550;
  // ceil(2^32 / 1100): exact floor division for values below 2^21
  localparam logic [21:0] RECIP_1100     = 22'd3904516;

  localparam logic [9:0] BANK1_BASE = 10'(NBINS);
  localparam logic [9:0] BIN_LAST   = 10'(NBINS - 1);
  localparam logic [9:0] MEM_LAST   = 10'(MEM_DEPTH - 1);

  // result status codes
  localparam logic [1:0] STAT_NONE = 2'd0;
  localparam logic [1:0] STAT_OK   = 2'd1;
  localparam logic [1:0] STAT_CRC  = 2'd2;
  localparam logic [1:0] STAT_ROT  = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_VERLEN,
    PH_FILL
  } phase_t;

  typedef enum logic [2:0] {
    S_RST_CLR,
    S_IDLE,
    S_READ,
    S_SETUP,
    S_SWAP_CLR,
    S_MUL,
    S_WR,
    S_DONE
  } state_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* src/lidar_packet_scan_binner.sv */
// ----------------------------------------------------------------------------
// lidar_packet_scan_binner
// Frames serial sensor packets, checks CRC-8 and bins points into a 360-degree
// double-buffered scan that can be read back one bin at a time.
// ----------------------------------------------------------------------------
// One transaction in gives exactly one transaction out. A bin read goes
// through a registered read of the scan memory. The last byte of a good
// packet starts the point sequencer: a setup state, then for each of the 12
// points a multiply state and a modulo-and-write state through the shared
// reciprocal multiplier, then a state to post the result. When the packet
// completes a rotation the new bank's 360 entries are cleared one per cycle
// before binning. After reset a clearing pass sweeps all 720 entries
// before the first transaction is taken. item_ready is high only when the
// sequencer is idle and the result register is free or being drained in the
// same cycle.
module lidar_packet_scan_binner (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic [8:0]  read_bin,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  packet_status,
  output logic [15:0] bin_distance,
  output logic [7:0]  bin_intensity
);
  import lpsb_pkg::*;

  state_t state, state_next;
  phase_t parse_phase, parse_phase_next;

  logic [5:0]  byte_count, byte_count_next;
  logic [7:0]  crc_running, crc_running_next;
  logic [15:0] start_angle, end_angle;
  logic [7:0]  dist_lo, dist_hi;
  logic [1:0]  pt_sub;
  logic [3:0]  pt_wr;
  logic [23:0] points [POINTS_PER_PACKET];

  logic [15:0] prev_start_angle;
  logic        have_prev_start;
  logic        active_bank;
  logic [9:0]  clr_addr;
  logic [3:0]  pt_i;
  logic [20:0] n_acc;
  logic [16:0] diff;
  logic [9:0]  q;
  logic [1:0]  pkt_stat;

  // scan memory: {valid, intensity, distance}
  logic [24:0] scan_mem [MEM_DEPTH];
  logic [24:0] rd_data;
  logic [9:0]  rd_addr;
  logic        wr_en;
  logic [9:0]  wr_addr;
  logic [24:0] wr_data;

  logic        acc, byte_acc, read_acc;
  logic        last_byte, crc_ok, pkt_go, in_fill;
  logic        rot;
  logic        load_res;
  logic [1:0]  res_status;
  logic [15:0] res_dist;
  logic [7:0]  res_inten;

  logic [20:0] un, x;
  logic [42:0] prod;
  logic [9:0]  q_mod;
  logic [9:0]  bank_base;
  logic [23:0] cur_pt;

  assign acc      = item_valid && item_ready;
  assign byte_acc = acc && !req_type;
  assign read_acc = acc && req_type;

  assign in_fill   = (parse_phase == PH_FILL);
  assign last_byte = in_fill && (byte_count == POS_CRC);
  assign crc_ok    = (rx_byte == crc_running);
  assign pkt_go    = byte_acc && last_byte && crc_ok;

  assign rot       = have_prev_start && (start_angle < prev_start_angle);
  assign bank_base = active_bank ? BANK1_BASE : 10'd0;

  // shared divide-by-1100 datapath
  assign un    = (n_acc >= FULL_TURN_NUM) ? (n_acc - FULL_TURN_NUM) : n_acc;
  assign x     = un + HALF_BIN_NUM;
  assign prod  = 43'(x) * 43'(RECIP_1100);
  assign q_mod = (q >= 10'(2 * NBINS)) ? (q - 10'(2 * NBINS)) :
                 (q >= 10'(NBINS))     ? (q - 10'(NBINS)) : q;
  assign cur_pt = points[pt_i];

  // parser next values
  always_comb begin
    parse_phase_next = parse_phase;
    byte_count_next  = byte_count;
    crc_running_next = crc_running;
    case (parse_phase)
      PH_HEADER: begin
        if (rx_byte == HDR_BYTE) begin
          parse_phase_next = PH_VERLEN;
          byte_count_next  = 6'd1;
          crc_running_next = crc_byte(8'd0, rx_byte);
        end
      end
      PH_VERLEN: begin
        if (rx_byte == VER_BYTE) begin
          parse_phase_next = PH_FILL;
          byte_count_next  = 6'd2;
          crc_running_next = crc_byte(crc_running, rx_byte);
        end else if (rx_byte == HDR_BYTE) begin
          byte_count_next  = 6'd1;
          crc_running_next = crc_byte(8'd0, rx_byte);
        end else begin
          parse_phase_next = PH_HEADER;
        end
      end
      PH_FILL: begin
        if (last_byte) begin
          parse_phase_next = PH_HEADER;
          byte_count_next  = 6'd0;
        end else begin
          byte_count_next  = byte_count + 6'd1;
          crc_running_next = crc_byte(crc_running, rx_byte);
        end
      end
      default: parse_phase_next = PH_HEADER;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_RST_CLR:  if (clr_addr == MEM_LAST) state_next = S_IDLE;
      S_IDLE: begin
        if (read_acc && (read_bin < 9'(NBINS))) state_next = S_READ;
        else if (pkt_go)                        state_next = S_SETUP;
      end
      S_READ:     state_next = S_IDLE;
      S_SETUP:    state_next = rot ? S_SWAP_CLR : S_MUL;
      S_SWAP_CLR: if (clr_addr == bank_base + BIN_LAST) state_next = S_MUL;
      S_MUL:      state_next = S_WR;
      S_WR:       state_next = (pt_i == 4'(POINTS_PER_PACKET - 1)) ? S_DONE : S_MUL;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_ready = (state == S_IDLE) && (!result_valid || result_ready);
    rd_addr    = {1'b0, read_bin} + (active_bank ? 10'd0 : BANK1_BASE);
    wr_en      = 1'b0;
    wr_addr    = clr_addr;
    wr_data    = '0;
    load_res   = 1'b0;
    res_status = STAT_NONE;
    res_dist   = '0;
    res_inten  = '0;
    case (state)
      S_RST_CLR, S_SWAP_CLR: wr_en = 1'b1;
      S_IDLE: begin
        if (read_acc && (read_bin >= 9'(NBINS))) begin
          load_res = 1'b1;
        end else if (byte_acc && !pkt_go) begin
          load_res   = 1'b1;
          res_status = last_byte ? STAT_CRC : STAT_NONE;
        end
      end
      S_READ: begin
        load_res = 1'b1;
        if (rd_data[24]) begin
          res_dist  = rd_data[15:0];
          res_inten = rd_data[23:16];
        end
      end
      S_WR: begin
        wr_en   = (cur_pt[15:0] != 16'd0);
        wr_addr = bank_base + q_mod;
        wr_data = {1'b1, cur_pt};
      end
      S_DONE: begin
        load_res   = 1'b1;
        res_status = pkt_stat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) scan_mem[wr_addr] <= wr_data;
    rd_data <= scan_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_RST_CLR;
      parse_phase      <= PH_HEADER;
      byte_count       <= '0;
      crc_running      <= '0;
      prev_start_angle <= '0;
      have_prev_start  <= 1'b0;
      active_bank      <= 1'b0;
      clr_addr         <= '0;
      result_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (byte_acc) begin
        parse_phase <= parse_phase_next;
        byte_count  <= byte_count_next;
        crc_running <= crc_running_next;
      end
      if (state == S_SETUP) begin
        prev_start_angle <= start_angle;
        have_prev_start  <= 1'b1;
        if (rot) begin
          active_bank <= !active_bank;
          clr_addr    <= active_bank ? 10'd0 : BANK1_BASE;
        end
      end else if (state == S_RST_CLR || state == S_SWAP_CLR) begin
        clr_addr <= clr_addr + 10'd1;
      end
      if (load_res)          result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (byte_acc) begin
      if (parse_phase_next == PH_VERLEN) begin
        pt_sub <= 2'd0;
        pt_wr  <= 4'd0;
      end
      if (in_fill) begin
        if (byte_count == POS_START_LO) start_angle[7:0]  <= rx_byte;
        if (byte_count == POS_START_HI) start_angle[15:8] <= rx_byte;
        if (byte_count == POS_END_LO)   end_angle[7:0]    <= rx_byte;
        if (byte_count == POS_END_HI)   end_angle[15:8]   <= rx_byte;
        if (byte_count >= POS_PTS_LO && byte_count <= POS_PTS_HI) begin
          case (pt_sub)
            2'd0: begin
              dist_lo <= rx_byte;
              pt_sub  <= 2'd1;
            end
            2'd1: begin
              dist_hi <= rx_byte;
              pt_sub  <= 2'd2;
            end
            default: begin
              points[pt_wr] <= {rx_byte, dist_hi, dist_lo};
              pt_wr  <= pt_wr + 4'd1;
              pt_sub <= 2'd0;
            end
          endcase
        end
      end
    end
    case (state)
      S_SETUP: begin
        n_acc    <= 21'({start_angle, 3'b000}) + 21'({start_angle, 1'b0}) + 21'(start_angle);
        diff     <= (end_angle < start_angle) ?
                    (17'(end_angle) + FULL_TURN_CDEG - 17'(start_angle)) :
                    (17'(end_angle) - 17'(start_angle));
        pt_i     <= 4'd0;
        pkt_stat <= rot ? STAT_ROT : STAT_OK;
      end
      S_MUL: q <= prod[41:32];
      S_WR: begin
        n_acc <= n_acc + 21'(diff);
        pt_i  <= pt_i + 4'd1;
      end
      default: ;
    endcase
    if (load_res) begin
      packet_status <= res_status;
      bin_distance  <= res_dist;
      bin_intensity <= res_inten;
    end
  end

  // checks
  a_ready_slot: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> (!result_valid || result_ready))
    else $error("input taken while result slot is blocked");

  a_pt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (pt_i < 4'(POINTS_PER_PACKET)))
    else $error("point index out of range");

  a_swap_stat: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP_CLR) |-> (pkt_stat == STAT_ROT))
    else $error("bank clear without rotation status");

  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> result_valid)
    else $error("packet result not posted");

endmodule

/* tb/lpsb_checker.sv */
// ----------------------------------------------------------------------------
// lpsb_checker: scoreboard for the lidar packet scan binner
// Watches both channels, predicts each result from its own model of the
// framer, CRC, angle interpolation and banked scan, and compares in order.
// ----------------------------------------------------------------------------
module lpsb_checker
  import lpsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic [8:0]  read_bin,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [1:0]  packet_status,
  input  logic [15:0] bin_distance,
  input  logic [7:0]  bin_intensity,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] distance;
    logic [7:0]  inten;
  } bin_result_t;

  bin_result_t expected_q[$];

  phase_t      m_phase;
  int          m_count;
  logic [7:0]  m_crc;
  logic [7:0]  m_pkt [PACKET_BYTES];
  logic [15:0] m_prev_start;
  logic        m_have_prev;
  logic [23:0] m_scan [MEM_DEPTH];
  logic        m_valid [MEM_DEPTH];
  logic        m_bank;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ((c << 1) ^ 8'h4D) : (c << 1);
    return c;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fails++;
  endtask

  // bins a completed packet, returns its status
  function automatic logic [1:0] bin_packet();
    int s, e, d, n, idx, base, off;
    logic [1:0] st;
    if (m_pkt[PACKET_BYTES-1] != m_crc) return STAT_CRC;
    st = STAT_OK;
    s = {m_pkt[5], m_pkt[4]};
    e = {m_pkt[43], m_pkt[42]};
    if (e < s) e += 36000;
    d = e - s;
    if (m_have_prev && s < m_prev_start) begin
      m_bank = ~m_bank;
      for (int k = 0; k < NBINS; k++) m_valid[m_bank*NBINS + k] = 1'b0;
      st = STAT_ROT;
    end
    m_prev_start = s[15:0];
    m_have_prev = 1'b1;
    base = m_bank * NBINS;
    for (int i = 0; i < POINTS_PER_PACKET; i++) begin
      off = 6 + 3*i;
      n = s*11 + d*i;
      if (n >= 396000) n -= 396000;
      idx = ((n + 550) / 1100) % NBINS;
      if ({m_pkt[off+1], m_pkt[off]} != 16'd0) begin
        m_scan[base+idx] = {m_pkt[off+2], m_pkt[off+1], m_pkt[off]};
        m_valid[base+idx] = 1'b1;
      end
    end
    return st;
  endfunction

  function automatic bin_result_t predict(input logic rt, input logic [7:0] b,
                                          input logic [8:0] rb);
    bin_result_t r;
    int k;
    r = '0;
    if (rt) begin
      if (rb < NBINS) begin
        k = (m_bank ? 0 : NBINS) + rb;
        if (m_valid[k]) begin
          r.distance = m_scan[k][15:0];
          r.inten = m_scan[k][23:16];
        end
      end
    end else begin
      case (m_phase)
        PH_HEADER: begin
          if (b == HDR_BYTE) begin
            m_pkt[0] = b; m_count = 1; m_crc = crc_step(8'd0, b); m_phase = PH_VERLEN;
          end
        end
        PH_VERLEN: begin
          if (b == VER_BYTE) begin
            m_pkt[1] = b; m_count = 2; m_crc = crc_step(m_crc, b); m_phase = PH_FILL;
          end else if (b == HDR_BYTE) begin
            m_pkt[0] = b; m_count = 1; m_crc = crc_step(8'd0, b);
          end else begin
            m_phase = PH_HEADER;
          end
        end
        default: begin
          if (m_count >= PACKET_BYTES) begin
            m_count = 0; m_phase = PH_HEADER;
          end else begin
            m_pkt[m_count] = b;
            if (m_count < PACKET_BYTES - 1) m_crc = crc_step(m_crc, b);
            m_count++;
            if (m_count == PACKET_BYTES) begin
              r.status = bin_packet();
              m_count = 0;
              m_phase = PH_HEADER;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  initial fails = 0;

  always @(posedge clk) begin
    bin_result_t exp_r;
    if (rst) begin
      m_phase = PH_HEADER;
      m_count = 0;
      m_crc = 8'd0;
      m_prev_start = 16'd0;
      m_have_prev = 1'b0;
      m_bank = 1'b0;
      for (int k = 0; k < MEM_DEPTH; k++) m_valid[k] = 1'b0;
      expected_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", packet_status, -1);
        end else begin
          exp_r = expected_q.pop_front();
          if (packet_status !== exp_r.status) report("packet_status", packet_status, exp_r.status);
          if (bin_distance !== exp_r.distance)
            report("bin_distance", bin_distance, exp_r.distance);
          if (bin_intensity !== exp_r.inten) report("bin_intensity", bin_intensity, exp_r.inten);
        end
      end
      if (item_valid && item_ready) expected_q.push_back(predict(req_type, rx_byte, read_bin));
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the lidar packet scan binner
// Sends framed packets (good, bad CRC, broken headers), line noise and bin
// reads with random idling on both sides; a checker module scores results.
// ----------------------------------------------------------------------------
module tb;
  import lpsb_pkg::*;

  localparam int N_ITEMS = 1900;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic        req_type;
  logic [7:0]  rx_byte;
  logic [8:0]  read_bin;
  logic        result_valid;
  logic        result_ready;
  logic [1:0]  packet_status;
  logic [15:0] bin_distance;
  logic [7:0]  bin_intensity;

  int          fails;
  int          pending;
  int          items_sent;  // accepted input transactions so far
  logic        item_acc;    // input transaction taken at the last rising edge
  bit          quiet;       // final stretch: no idling on either side
  int          next_start;  // running start angle, centidegrees

  lidar_packet_scan_binner uut (.*);

  lpsb_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous cap: reset sweep, rotations, long hold-off and bursts included
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) item_acc <= item_valid && item_ready;

  // receiver side: random stall bursts, one long hold-off to back up the block
  initial begin
    int k;
    bit held;
    held = 0;
    result_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && items_sent >= 600) begin
        held = 1;
        result_ready = 1'b0;
        for (k = 0; k < 500; k++) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        result_ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        result_ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // one transaction on the input channel; called at a falling edge
  task automatic send(input logic rt, input logic [7:0] b, input logic [8:0] rb);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    item_valid = 1'b1;
    req_type = rt;
    rx_byte = b;
    read_bin = rb;
    do @(negedge clk); while (!item_acc);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send(1'b0, b, 9'($urandom_range(0, 511)));
  endtask

  task automatic send_read(input logic [8:0] rb);
    send(1'b1, 8'($urandom), rb);
  endtask

  // full packet; zero_pct sets how often a point distance is zero
  task automatic send_packet(input logic [15:0] st, input logic [15:0] en,
                             input bit bad_crc, input int zero_pct, input bit extreme);
    logic [7:0] pkt [PACKET_BYTES];
    logic [7:0] crc;
    pkt[0] = HDR_BYTE;
    pkt[1] = VER_BYTE;
    pkt[2] = 8'($urandom);
    pkt[3] = 8'($urandom);
    pkt[4] = st[7:0];
    pkt[5] = st[15:8];
    for (int i = 0; i < POINTS_PER_PACKET; i++) begin
      if (extreme) begin
        pkt[6+3*i] = 8'hFF; pkt[7+3*i] = 8'hFF; pkt[8+3*i] = 8'hFF;
      end else if ($urandom_range(0, 99) < zero_pct) begin
        pkt[6+3*i] = 8'h00; pkt[7+3*i] = 8'h00; pkt[8+3*i] = 8'($urandom);
      end else begin
        pkt[6+3*i] = 8'($urandom); pkt[7+3*i] = 8'($urandom); pkt[8+3*i] = 8'($urandom);
      end
    end
    pkt[42] = en[7:0];
    pkt[43] = en[15:8];
    pkt[44] = 8'($urandom);
    pkt[45] = 8'($urandom);
    crc = 8'd0;
    for (int i = 0; i < PACKET_BYTES - 1; i++) crc = crc_step(crc, pkt[i]);
    pkt[46] = bad_crc ? (crc ^ 8'(1 << $urandom_range(0, 7))) : crc;
    for (int i = 0; i < PACKET_BYTES; i++) begin
      // reads mid-packet must leave the parser alone
      if ($urandom_range(0, 59) == 0) send_read(9'($urandom_range(0, 511)));
      send_byte(pkt[i]);
    end
  endtask

  // next start angle of a sweep; wraps to a lower value to close the scan
  task automatic good_random_packet();
    logic [15:0] st, en;
    case ($urandom_range(0, 9))
      0: st = 16'($urandom);
      default: begin
        next_start += $urandom_range(200, 6000);
        if (next_start >= 36000) next_start = $urandom_range(0, 3000);
        st = 16'(next_start);
      end
    endcase
    if ($urandom_range(0, 7) == 0) en = 16'($urandom);
    else en = 16'((st + $urandom_range(0, 1500)) % 36000);
    send_packet(st, en, 1'b0, $urandom_range(0, 3) == 0 ? 60 : 10, 1'b0);
  endtask

  initial begin
    int pick;
    int k;
    rst = 1'b1;
    item_valid = 1'b0;
    req_type = 1'b0;
    rx_byte = 8'd0;
    read_bin = 9'd0;
    items_sent = 0;
    quiet = 0;
    next_start = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: reads of an empty scan, including out-of-range bins
    send_read(9'd0);
    send_read(9'd359);
    send_read(9'd360);
    send_read(9'd511);
    // angle extremes, wrap through zero, angles above a full turn
    send_packet(16'd0, 16'd0, 1'b0, 0, 1'b1);
    send_packet(16'd35990, 16'd10, 1'b0, 0, 1'b0);
    send_packet(16'd65535, 16'd65535, 1'b0, 0, 1'b0);
    send_packet(16'd40000, 16'd1000, 1'b0, 50, 1'b0);
    // lower start closes the scan; then read it back
    send_packet(16'd100, 16'd1200, 1'b0, 100, 1'b0);
    send_read(9'd0);
    send_read(9'd359);
    send_read(9'd1);
    // CRC error, repeated header, header followed by a wrong byte
    send_packet(16'd5000, 16'd6000, 1'b1, 0, 1'b0);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_packet(16'd7000, 16'd8000, 1'b0, 0, 1'b0);
    send_byte(HDR_BYTE);
    send_byte(8'h00);
    send_byte(8'hFF);

    // random: mostly well-formed packets, some damage and noise, frequent reads
    while (items_sent < N_ITEMS) begin
      if (items_sent > N_ITEMS * 85 / 100) quiet = 1;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        good_random_packet();
      end else if (pick < 73) begin
        send_packet(16'($urandom), 16'($urandom), 1'b1, 20, 1'b0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
      end else if (pick < 86) begin
        // broken framing: repeated headers, wrong second byte, truncated body
        send_byte(HDR_BYTE);
        if ($urandom_range(0, 1)) send_byte(HDR_BYTE);
        if ($urandom_range(0, 1)) send_byte(8'($urandom));
        else begin
          send_byte(VER_BYTE);
          repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 8)) send_read(9'($urandom_range(0, 511)));
      end
    end
    // finish any truncated frame so no packet is left half parsed
    quiet = 1;
    good_random_packet();
    for (k = 0; k < 360; k += 7) send_read(9'(k));
    item_valid = 1'b0;

    k = 0;
    while (pending != 0 && k < 100000) begin
      @(negedge clk);
      k++;
    end
    repeat (500) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
